[rtl/core/voim_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package voim_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_RES      = 3'd3;
  localparam logic [2:0] REG_INV_RES  = 3'd4;
  localparam logic [2:0] REG_INFLATE  = 3'd5;

  // Base index width: a 21-bit difference times a 21-bit reciprocal, shifted by 20.
  localparam int BASE_W = 23;
  localparam int FRAC_W = 20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the point minus the origin
    logic first;     // register the products and set the neighbour offsets to their start
    logic step;      // advance to the next neighbour
    logic rd;        // read the occupancy bit of the current neighbour
    logic wr;        // mark the current neighbour and emit it
    logic clr;       // clear one store entry at the sweep address
  } voim_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_grid;   // current neighbour lies inside the grid
    logic occ;       // registered occupancy bit of current neighbour
    logic last_nb;   // current neighbour is the last of the neighbourhood
    logic clr_done;  // the clearing sweep is at its final entry
  } voim_sts_t;

endpackage
`default_nettype wire

[rtl/core/voim_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module voim_ctrl
  import voim_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  voim_sts_t  sts,
  output voim_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_NEXT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence: clear after reset, then a multiply state, then read, check and mark per neighbour.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.first = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.wr = sts.in_grid && !sts.occ;
        state_nxt = sts.last_nb ? S_IDLE : S_NEXT;
      end
      S_NEXT: begin
        cmd.step = 1'b1;
        state_nxt = S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  // A mark only happens while a neighbour is being checked.
  a_wr_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> state_r == S_CHECK) else $error("mark outside check");
  // The clearing sweep never resumes once finished.
  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> state_r != S_CLEAR) else $error("clear restarted");
  // A start while idle always begins an item.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_MUL) else $error("start lost");

endmodule
`default_nettype wire

[rtl/core/voim_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module voim_dp
  import voim_pkg::*;
#(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 32,
  localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1,
  localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1,
  localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1
)(
  input  wire               clk,
  input  wire               rst_n,
  input  voim_cmd_t         cmd,
  output voim_sts_t         sts,
  input  wire signed [19:0] px,
  input  wire signed [19:0] py,
  input  wire signed [19:0] pz,
  input  wire signed [18:0] org_x,
  input  wire signed [18:0] org_y,
  input  wire signed [18:0] org_z,
  input  wire        [11:0] res,
  input  wire        [20:0] inv_res,
  input  wire               inflate,
  output logic [5:0]        out_cell_x,
  output logic [5:0]        out_cell_y,
  output logic [4:0]        out_cell_z,
  output logic signed [20:0] out_center_x,
  output logic signed [20:0] out_center_y,
  output logic signed [20:0] out_center_z
);

  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int AW     = $clog2(CELLS);
  localparam int PW     = 43;

  // Point differences, registered at start.
  logic signed [20:0] dx_r, dy_r, dz_r;
  // Scaled products, registered after the multiplier.
  logic signed [PW-1:0] mx_r, my_r, mz_r;
  logic signed [PW-1:0] mx, my, mz;
  logic signed [BASE_W-1:0] bx, by, bz;
  logic signed [1:0] ox_r, oy_r, oz_r;
  logic signed [BASE_W-1:0] nx, ny, nz;
  logic in_grid;
  logic [AW-1:0] addr, clr_addr_r;
  logic occ_r;
  logic mem_r [CELLS];
  logic signed [1:0] s_neg;
  logic last_nb;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= 21'(px) - 21'(org_x);
      dy_r <= 21'(py) - 21'(org_y);
      dz_r <= 21'(pz) - 21'(org_z);
    end
  end

  // Multiply in the cycle after the load; arithmetic shift floors.
  assign mx = PW'(dx_r) * $signed({1'b0, inv_res});
  assign my = PW'(dy_r) * $signed({1'b0, inv_res});
  assign mz = PW'(dz_r) * $signed({1'b0, inv_res});

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      mx_r <= mx;
      my_r <= my;
      mz_r <= mz;
    end
  end

  assign bx = BASE_W'(mx_r >>> FRAC_W);
  assign by = BASE_W'(my_r >>> FRAC_W);
  assign bz = BASE_W'(mz_r >>> FRAC_W);

  // Offsets: z always spans -1..1, x and y span -s..s.
  assign s_neg = inflate ? -2'sd1 : 2'sd0;
  assign last_nb = (ox_r == $signed({1'b0, inflate})) &&
                   (oy_r == $signed({1'b0, inflate})) && (oz_r == 2'sd1);

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      ox_r <= s_neg;
      oy_r <= s_neg;
      oz_r <= -2'sd1;
    end else if (cmd.step) begin
      if (oz_r != 2'sd1) oz_r <= oz_r + 2'sd1;
      else begin
        oz_r <= -2'sd1;
        if (oy_r != $signed({1'b0, inflate})) oy_r <= oy_r + 2'sd1;
        else begin
          oy_r <= s_neg;
          ox_r <= ox_r + 2'sd1;
        end
      end
    end
  end

  assign nx = bx + BASE_W'(ox_r);
  assign ny = by + BASE_W'(oy_r);
  assign nz = bz + BASE_W'(oz_r);
  assign in_grid = !nx[BASE_W-1] && !ny[BASE_W-1] && !nz[BASE_W-1] &&
                   (nx < BASE_W'(GRID_X)) && (ny < BASE_W'(GRID_Y)) &&
                   (nz < BASE_W'(GRID_Z));
  assign addr = AW'((nx[XW-1:0] * GRID_Y + ny[YW-1:0]) * GRID_Z + nz[ZW-1:0]);

  // Occupancy store: one write port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clr) mem_r[clr_addr_r] <= 1'b0;
    else if (cmd.wr) mem_r[addr] <= 1'b1;
    if (cmd.rd) occ_r <= mem_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + AW'(1);
  end

  assign sts.in_grid  = in_grid;
  assign sts.occ      = occ_r;
  assign sts.last_nb  = last_nb;
  assign sts.clr_done = (clr_addr_r == AW'(CELLS - 1));

  // The most recently marked cell and its centre, held until it is sent.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_cell_x   <= 6'(nx);
      out_cell_y   <= 6'(ny);
      out_cell_z   <= 5'(nz);
      out_center_x <= 21'(org_x) + 21'(nx * $signed({1'b0, res})) + 21'(res >> 1);
      out_center_y <= 21'(org_y) + 21'(ny * $signed({1'b0, res})) + 21'(res >> 1);
      out_center_z <= 21'(org_z) + 21'(nz * $signed({1'b0, res})) + 21'(res >> 1);
    end
  end

  // Marking only touches cells inside the grid.
  a_wr_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> in_grid) else $error("mark outside grid");
  // Clearing and marking never overlap.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && cmd.wr)) else $error("clear and mark together");
  // A read is always followed by the check cycle, never by another read.
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !cmd.rd) else $error("double read");

endmodule
`default_nettype wire

[rtl/core/voxel_occupancy_inflate_mark_unit.sv]
// Channel   Direction  Ports                                   Handshake
// in        input      in_point_x/y/z                          start & !busy
// out       output     out_cell_*, out_center_*, out_last_*    out_valid strobe
// cfg       input      cfg_index, cfg_data                     cfg_valid & cfg_ready
// After reset the occupancy store is swept clear, one entry a cycle, over all
// GRID_X*GRID_Y*GRID_Z entries; busy stays high meanwhile.
// An item runs from accept through the multiply state, then the occupancy
// read, check and mark done one neighbour at a time (27 neighbours with
// inflation on, 3 off); busy stays high until its last neighbour is checked.
// A marked cell is sent the cycle after the next mark, or the cycle after the
// idle cycle that ends its point, flagged as last; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module voxel_occupancy_inflate_mark_unit
  import voim_pkg::*;
#(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64,
  parameter int GRID_Z = 32
)(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire signed [19:0] in_point_x,
  input  wire signed [19:0] in_point_y,
  input  wire signed [19:0] in_point_z,
  output logic              out_valid,
  output logic [5:0]        out_cell_x,
  output logic [5:0]        out_cell_y,
  output logic [4:0]        out_cell_z,
  output logic signed [20:0] out_center_x,
  output logic signed [20:0] out_center_y,
  output logic signed [20:0] out_center_z,
  output logic              out_last_of_point,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [2:0]        cfg_index,
  input  wire  [20:0]       cfg_data
);

  voim_cmd_t cmd;
  voim_sts_t sts;
  logic signed [18:0] org_x_r, org_y_r, org_z_r;
  logic [11:0] res_r;
  logic [20:0] inv_res_r;
  logic inflate_r;
  logic [5:0] cx, cy;
  logic [4:0] cz;
  logic signed [20:0] ex, ey, ez;
  logic hv_r;
  logic send;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= -19'sd4800;
      org_y_r <= -19'sd4800;
      org_z_r <= '0;
      res_r <= 12'd150;
      inv_res_r <= 21'd6991;
      inflate_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x_r <= cfg_data[18:0];
        REG_ORIGIN_Y: org_y_r <= cfg_data[18:0];
        REG_ORIGIN_Z: org_z_r <= cfg_data[18:0];
        REG_RES:      res_r <= cfg_data[11:0];
        REG_INV_RES:  inv_res_r <= cfg_data;
        REG_INFLATE:  inflate_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  voim_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  voim_dp #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z),
    .org_x(org_x_r), .org_y(org_y_r), .org_z(org_z_r),
    .res(res_r), .inv_res(inv_res_r), .inflate(inflate_r),
    .out_cell_x(cx), .out_cell_y(cy), .out_cell_z(cz),
    .out_center_x(ex), .out_center_y(ey), .out_center_z(ez)
  );

  // The held cell leaves at the next mark, or flagged as last once the point ends.
  assign send = hv_r && (cmd.wr || !busy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      out_valid <= 1'b0;
      out_last_of_point <= 1'b0;
    end else begin
      out_valid <= send;
      out_last_of_point <= send && !cmd.wr;
      if (cmd.wr) hv_r <= 1'b1;
      else if (!busy) hv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_cell_x <= cx; out_cell_y <= cy; out_cell_z <= cz;
      out_center_x <= ex; out_center_y <= ey; out_center_z <= ez;
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_point |-> out_valid) else $error("last without valid");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready) else $error("cfg stalled");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");

endmodule
`default_nettype wire
